>>> sv/hpfp_pkg.sv
// Shared types and constants for the humidity PID fan PWM unit.
// No dependencies; imported by hpfp_core, the top level, the checker and the testbench.
package hpfp_pkg;

  localparam int HUM_W   = 11;
  localparam int ERR_W   = 12;
  localparam int INTEG_W = 11;
  localparam int PWR_W   = 8;
  localparam int SUM_W   = 18;

  localparam logic [HUM_W-1:0] TARGET_RST     = 11'd960;
  localparam logic [PWR_W-1:0] DUTY_FLOOR_RST = 8'd0;

  localparam logic signed [13:0] INTEG_LIM_POS = 14'sd800;
  localparam logic signed [13:0] INTEG_LIM_NEG = -14'sd800;

  localparam logic signed [SUM_W-1:0] KP_POS = 18'sd10;
  localparam logic signed [SUM_W-1:0] KP_NEG = 18'sd50;
  localparam logic signed [SUM_W-1:0] KD     = 18'sd5;

  // register index, taken from paddr[2]
  localparam logic REG_TARGET     = 1'b0;
  localparam logic REG_DUTY_FLOOR = 1'b1;

  localparam int CFG_AW = 3;

  typedef struct packed {
    logic signed [ERR_W-1:0]   prev_err;
    logic signed [INTEG_W-1:0] integ;
    logic [PWR_W-1:0]          last_power;
  } hpfp_state_t;

  typedef struct packed {
    logic             switched;
    logic [PWR_W-1:0] pwm_duty;
    logic [PWR_W-1:0] fan_power;
  } hpfp_result_t;

endpackage

>>> sv/hpfp_core.sv
// PID step: error, clamped trapezoid integral, saturated power, PWM mapping.
// Purely combinational; depends on hpfp_pkg.
module hpfp_core import hpfp_pkg::*; (
  input  logic [HUM_W-1:0] humidity,
  input  logic [HUM_W-1:0] target,
  input  logic [PWR_W-1:0] duty_floor,
  input  hpfp_state_t      st,
  output hpfp_state_t      st_nxt,
  output hpfp_result_t     res
);

  logic signed [ERR_W-1:0]   err;
  logic signed [13:0]        integ_raw;
  logic signed [INTEG_W-1:0] integ_clamp;
  logic signed [12:0]        diff;
  logic signed [SUM_W-1:0]   err_ext;
  logic signed [SUM_W-1:0]   prop;
  logic signed [SUM_W-1:0]   deriv;
  logic signed [SUM_W-1:0]   sum;
  logic [PWR_W-1:0]          power;
  logic [15:0]               prod;
  logic [16:0]               div_tmp;
  logic [8:0]                duty_sum;
  logic [PWR_W-1:0]          duty;

  assign err = $signed({1'b0, humidity}) - $signed({1'b0, target});

  assign integ_raw = {{3{st.integ[INTEG_W-1]}}, st.integ}
                   + {{2{err[ERR_W-1]}}, err}
                   + {{2{st.prev_err[ERR_W-1]}}, st.prev_err};

  always_comb begin
    if (integ_raw > INTEG_LIM_POS) begin
      integ_clamp = INTEG_LIM_POS[INTEG_W-1:0];
    end else if (integ_raw < INTEG_LIM_NEG) begin
      integ_clamp = INTEG_LIM_NEG[INTEG_W-1:0];
    end else begin
      integ_clamp = integ_raw[INTEG_W-1:0];
    end
  end

  assign err_ext = {{(SUM_W-ERR_W){err[ERR_W-1]}}, err};
  assign prop    = err[ERR_W-1] ? err_ext * KP_NEG : err_ext * KP_POS;
  assign diff    = {err[ERR_W-1], err} - {st.prev_err[ERR_W-1], st.prev_err};
  assign deriv   = {{(SUM_W-13){diff[12]}}, diff} * KD;
  assign sum     = prop + {{(SUM_W-INTEG_W){integ_clamp[INTEG_W-1]}}, integ_clamp} + deriv;

  // floor(sum/16), saturated to 0..255; non-positive sums give zero
  always_comb begin
    if (sum[SUM_W-1] || (sum == '0)) begin
      power = '0;
    end else if (|sum[SUM_W-2:12]) begin
      power = '1;
    end else begin
      power = sum[11:4];
    end
  end

  // x/255 for x < 2^16 as (x + (x >> 8) + 1) >> 8
  assign prod     = power * (8'd255 - duty_floor);
  assign div_tmp  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
  assign duty_sum = {1'b0, duty_floor} + {1'b0, div_tmp[15:8]};
  assign duty     = (power == '0) ? '0 : duty_sum[7:0];

  assign res.fan_power = power;
  assign res.pwm_duty  = duty;
  assign res.switched  = (power != '0) != (st.last_power != '0);

  assign st_nxt.prev_err   = err;
  assign st_nxt.integ      = integ_clamp;
  assign st_nxt.last_power = power;

endmodule

>>> sv/humidity_pid_fan_pwm_unit.sv
// Humidity PID fan controller: input word register, one compute pass, result register.
// Each word passes two register stages, the input register and then the result register;
// throughput one word per cycle while out_tready keeps the result stream moving.
// Synchronous active-low reset clears valids, loop state and config to defaults.
// Depends on hpfp_pkg and hpfp_core.
module humidity_pid_fan_pwm_unit import hpfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,    // [10:0] humidity, [15:11] zero
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,   // [7:0] fan_power, [15:8] pwm_duty, [16] switched
  // config port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  // config registers
  logic [HUM_W-1:0] target_r;
  logic [PWR_W-1:0] duty_floor_r;
  logic             cfg_wr;

  // input stage
  logic             s1_vld_r;
  logic [HUM_W-1:0] s1_hum_r;

  // loop state carried between words
  hpfp_state_t st_r, st_nxt;

  // result stage
  logic         out_vld_r;
  hpfp_result_t out_res_r;
  hpfp_result_t res;

  logic out_free;
  logic s1_fire;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      REG_TARGET:     cfg_prdata = {{(32-HUM_W){1'b0}}, target_r};
      REG_DUTY_FLOOR: cfg_prdata = {{(32-PWR_W){1'b0}}, duty_floor_r};
      default:        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= TARGET_RST;
      duty_floor_r <= DUTY_FLOOR_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_TARGET:     target_r     <= cfg_pwdata[HUM_W-1:0];
        REG_DUTY_FLOOR: duty_floor_r <= cfg_pwdata[PWR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: result register frees when empty or taken; the input stage
  // moves into it in the same cycle, so a new word lands every cycle unless the output stalls.
  assign out_free  = !out_vld_r || out_tready;
  assign s1_fire   = s1_vld_r && out_free;
  assign in_tready = !s1_vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_hum_r <= in_tdata[HUM_W-1:0];
    end
  end

  // Single compute pass; loop state updates as the word moves to the output.
  hpfp_core u_core (
    .humidity   (s1_hum_r),
    .target     (target_r),
    .duty_floor (duty_floor_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, out_res_r.switched, out_res_r.pwm_duty, out_res_r.fan_power};

endmodule

>>> sv/hpfp_check.sv
// Port-level checks for the humidity PID fan unit, bound to the top level.
// Sees only the top-level ports; no package dependency.
module hpfp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // duty is zero exactly when power is zero
  a_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[7:0] == 8'd0) == (out_tdata[15:8] == 8'd0)))
    else $error("pwm duty and fan power disagree on off state");

  // mapping never lowers the duty below the power
  a_duty_ge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:8] >= out_tdata[7:0]))
    else $error("pwm duty below fan power");

  // full power maps to full duty
  a_duty_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] == 8'd255) |-> (out_tdata[15:8] == 8'd255))
    else $error("full power not mapped to full duty");

endmodule

bind humidity_pid_fan_pwm_unit hpfp_check u_hpfp_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> sim/hpfp_fan_checker.sv
// Scoreboard for the humidity PID fan PWM unit: follows the config port and both streams,
// predicts each result word and compares it field by field. Depends on hpfp_pkg.
module hpfp_fan_checker import hpfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [15:0]       in_tdata,    // [10:0] humidity, [15:11] zero
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [23:0]       out_tdata,   // [7:0] fan_power, [15:8] pwm_duty, [16] switched
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                mismatches,
  output int                pending
);

  localparam int INTEG_CLAMP = 800;
  localparam int GAIN_P      = 10;
  localparam int NEG_BOOST   = 5;   // proportional term is five times stronger below target
  localparam int GAIN_D      = 5;
  localparam int FULL_SCALE  = 255;

  localparam int RES_W = $bits(hpfp_result_t);

  logic [HUM_W-1:0]          set_target;
  logic [PWR_W-1:0]          set_duty_floor;
  logic signed [ERR_W-1:0]   ctl_prev_err;
  logic signed [INTEG_W-1:0] ctl_integ;
  logic [PWR_W-1:0]          ctl_last_power;
  hpfp_result_t              expected_fan_q[$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    mismatches++;
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
  endtask

  // One control step: returns the result word and advances the loop state.
  function automatic hpfp_result_t step_fan_loop(input logic [HUM_W-1:0] hum);
    int err;
    int integ;
    int drive;
    int power;
    int duty;
    hpfp_result_t res;
    err   = int'(hum) - int'(set_target);
    integ = int'(ctl_integ) + err + int'(ctl_prev_err);
    if (integ > INTEG_CLAMP)
      integ = INTEG_CLAMP;
    else if (integ < -INTEG_CLAMP)
      integ = -INTEG_CLAMP;
    drive = GAIN_P * err;
    if (err < 0)
      drive = drive * NEG_BOOST;
    drive = drive + integ + GAIN_D * (err - int'(ctl_prev_err));
    if (drive <= 0)
      power = 0;
    else begin
      power = drive / 16;
      if (power > FULL_SCALE)
        power = FULL_SCALE;
    end
    if (power != 0)
      duty = int'(set_duty_floor) +
             (power * (FULL_SCALE - int'(set_duty_floor))) / FULL_SCALE;
    else
      duty = 0;
    if (duty > FULL_SCALE)
      duty = FULL_SCALE;
    res.fan_power = power[PWR_W-1:0];
    res.pwm_duty  = duty[PWR_W-1:0];
    res.switched  = (power != 0) != (ctl_last_power != '0);
    ctl_prev_err   = err[ERR_W-1:0];
    ctl_integ      = integ[INTEG_W-1:0];
    ctl_last_power = power[PWR_W-1:0];
    return res;
  endfunction

  always @(posedge clk) begin
    hpfp_result_t got;
    hpfp_result_t want;
    if (!rst_n) begin
      set_target     = TARGET_RST;
      set_duty_floor = DUTY_FLOOR_RST;
      ctl_prev_err   = '0;
      ctl_integ      = '0;
      ctl_last_power = '0;
      expected_fan_q.delete();
      pending        = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[2] == REG_TARGET)
          set_target = cfg_pwdata[HUM_W-1:0];
        else
          set_duty_floor = cfg_pwdata[PWR_W-1:0];
      end
      if (in_tvalid && in_tready)
        expected_fan_q.push_back(step_fan_loop(in_tdata[HUM_W-1:0]));
      if (out_tvalid && out_tready) begin
        got = hpfp_result_t'(out_tdata[RES_W-1:0]);
        if (expected_fan_q.size() == 0)
          report_mismatch("unexpected result word", -1, int'(out_tdata));
        else begin
          want = expected_fan_q.pop_front();
          if (got.fan_power != want.fan_power)
            report_mismatch("fan_power", int'(want.fan_power), int'(got.fan_power));
          if (got.pwm_duty != want.pwm_duty)
            report_mismatch("pwm_duty", int'(want.pwm_duty), int'(got.pwm_duty));
          if (got.switched != want.switched)
            report_mismatch("switched", int'(want.switched), int'(got.switched));
        end
        if (out_tdata[23:RES_W] != '0)
          report_mismatch("tdata padding", 0, int'(out_tdata[23:RES_W]));
      end
      pending = expected_fan_q.size();
    end
  end

endmodule

>>> sim/testbench.sv
// Top of the humidity PID fan PWM unit bench: clock, reset, config writes and stream stimulus.
// Depends on hpfp_pkg, humidity_pid_fan_pwm_unit and hpfp_fan_checker.
module testbench;
  import hpfp_pkg::*;

  // Longest run of cycles with no handshake at all before the run is called hung.
  // The worst legal stretch is the receiver hold-off below plus a drain, far shorter.
  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 300;   // receiver hold-off, long enough to back up the input
  localparam int PHASES      = 9;
  localparam int PHASE_WORDS = 75;

  // Register i sits at byte address 4*i.
  localparam logic [CFG_AW-1:0] TARGET_ADDR     = CFG_AW'({REG_TARGET, 2'b00});
  localparam logic [CFG_AW-1:0] DUTY_FLOOR_ADDR = CFG_AW'({REG_DUTY_FLOOR, 2'b00});

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_EVERY_THIRD} rx_mode_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [15:0]       in_tdata;    // [10:0] humidity, [15:11] zero
  logic              out_tvalid;
  logic              out_tready;
  logic [23:0]       out_tdata;   // [7:0] fan_power, [15:8] pwm_duty, [16] switched
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  int mismatches;
  int pending;
  bit rx_hold_req;   // set by the stimulus, cleared by the receiver once its hold-off is done

  // Directed samples around the default setpoint of 960: zero error, small errors either way,
  // full-scale positive and negative errors that drive the integral into both clamps,
  // saturated power, and hard on/off swings that toggle the switched flag.
  int directed_hum[25] = '{960, 961, 962, 970, 980, 1000, 1100, 1300, 1600, 2047,
                           2047, 2047, 0, 0, 960, 976, 2047, 959, 944, 1024,
                           1040, 0, 1600, 960, 1};

  // Setpoint / duty floor per random phase; -1 picks a random value at run time.
  // First two phases hit the register extremes.
  int phase_target[PHASES] = '{0, 2047, 1600, 960, -1, -1, -1, -1, -2};
  int phase_min[PHASES]    = '{255, 0, 1, 128, -1, -1, -1, 255, -1};

  humidity_pid_fan_pwm_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  hpfp_fan_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: any accepted word or register write restarts the count.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("humidity_pid_fan_pwm_unit test failed");
    $finish;
  end

  // Result side: out_tready follows a randomly chosen pattern, picked anew after each run of
  // random length, so stalls land on every phase of the pipeline. On request it holds off for
  // HOLD_CYCLES so the block fills up and drops in_tready.
  initial begin
    rx_mode_t mode;
    int       left;
    out_tready = 1'b0;
    mode       = RX_OPEN;
    left       = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 120);
        end
        left--;
        case (mode)
          RX_OPEN:        out_tready <= 1'b1;
          RX_COIN:        out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE:      out_tready <= ($urandom_range(0, 3) == 0);
          RX_EVERY_THIRD: out_tready <= (left % 3 == 0);
          default:        out_tready <= 1'b1;
        endcase
      end
    end
  end

  // Offer one humidity word at the current falling edge and hold it until accepted.
  // Returns at the next falling edge with in_tvalid still high, so back-to-back words
  // never see valid dropped and raised in the same step.
  task automatic send_word(input logic [HUM_W-1:0] hum);
    in_tvalid <= 1'b1;
    in_tdata  <= 16'(hum);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stop sending and wait for every predicted result to come out, then idle on spare cycles
  // (every accepted word makes one result).
  task automatic drain_block();
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [HUM_W-1:0] clamp_hum(input int v);
    if (v < 0)
      return '0;
    if (v > 2047)
      return '1;
    return v[HUM_W-1:0];
  endfunction

  // One random phase. Most samples follow a slow random walk around the setpoint, which is
  // what a real sensor does and what keeps the integral off its clamps; the rest are
  // uniform noise, full-scale jumps and near-setpoint jitter. Words go out in bursts of
  // random length with random gaps, and some bursts run straight into the next one.
  task automatic run_loop_phase(input logic [HUM_W-1:0] center, input bit with_hold,
                                input bit with_drain);
    int               walk;
    int               burst_left;
    int               pick;
    logic [HUM_W-1:0] hum;
    walk       = int'(center);
    burst_left = 0;
    for (int i = 0; i < PHASE_WORDS; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if (i != 0 && $urandom_range(0, 2) != 0) begin
          in_tvalid <= 1'b0;
          repeat ($urandom_range(1, 7)) @(negedge clk);
        end
      end
      burst_left--;
      // receiver stops while words keep coming
      if (with_hold && i == PHASE_WORDS / 3)
        rx_hold_req = 1'b1;
      // sender waits until everything in flight has come out
      if (with_drain && i == PHASE_WORDS / 2)
        drain_block();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        walk = walk + int'($urandom_range(0, 64)) - 32;
        hum  = clamp_hum(walk);
        walk = int'(hum);
      end else if (pick < 85)
        hum = HUM_W'($urandom_range(0, 2047));
      else if (pick < 93) begin
        case ($urandom_range(0, 2))
          0:       hum = '0;
          1:       hum = '1;
          default: hum = 11'd1600;
        endcase
      end else
        hum = clamp_hum(int'(center) + int'($urandom_range(0, 32)) - 16);
      send_word(hum);
    end
  endtask

  initial begin
    int tgt;
    int minp;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rx_hold_req = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part runs on the reset-time settings; an occasional one-cycle gap.
    foreach (directed_hum[k]) begin
      if ($urandom_range(0, 3) == 0) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
      send_word(directed_hum[k][HUM_W-1:0]);
    end

    // Random phases. Settings only change with the block idle; loop state carries over.
    // Unused upper bits of pwdata are random, the block must ignore them.
    for (int p = 0; p < PHASES; p++) begin
      drain_block();
      tgt  = phase_target[p];
      minp = phase_min[p];
      if (tgt == -1)
        tgt = $urandom_range(300, 1400);
      else if (tgt == -2)
        tgt = $urandom_range(0, 2047);
      if (minp < 0)
        minp = $urandom_range(0, 255);
      cfg_write(TARGET_ADDR, ($urandom & ~32'h7FF) | 32'(tgt));
      cfg_write(DUTY_FLOOR_ADDR, ($urandom & ~32'hFF) | 32'(minp));
      run_loop_phase(tgt[HUM_W-1:0], p == 3, p == 5);
    end

    drain_block();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("humidity_pid_fan_pwm_unit test passed");
    else
      $display("humidity_pid_fan_pwm_unit test failed");
    $finish;
  end

endmodule

>>> sim.f
sv/hpfp_pkg.sv
sv/hpfp_core.sv
sv/humidity_pid_fan_pwm_unit.sv
sv/hpfp_check.sv
sim/hpfp_fan_checker.sv
sim/testbench.sv
